// ----- src/taysin_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// taysin_pkg
// Shared widths, constants, reciprocal table and stage types of the
// series sine pipeline.
// ----------------------------------------------------------------------------
package taysin_pkg;

	// Number of series terms (first term plus the refined ones)
	localparam int TERM_COUNT = 10;
	localparam int TERM_MAX   = 10;

	// Field widths
	localparam int ANGLE_W = 16;
	localparam int SINE_W  = 16;

	// Internal widths: |x| is Q12 below 2^15, x^2 is Q24, terms and sum are Q24
	localparam int X_W    = 15;
	localparam int X2_W   = 2 * X_W;
	localparam int FRAC_W = 12;
	localparam int T_W    = 32;
	localparam int S_W    = 34;
	localparam int PROD_W = T_W + X2_W;
	localparam int P_SH   = 24;
	localparam int P_W    = PROD_W - P_SH;
	localparam int PL_W   = 19;
	localparam int PH_W   = P_W - PL_W;
	localparam int R_W    = 30;
	localparam int PPL_W  = PL_W + R_W;
	localparam int PPH_W  = PH_W + R_W;
	localparam int ACC_W  = P_W + R_W + 1;
	localparam int R_SH   = 32;
	localparam int Q_SH   = 10;
	localparam int MAG_W  = S_W - Q_SH + 1;

	// Range limit of |angle| (6.4 rad in Q12)
	localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 16'd26214;

	// Saturation bounds of the result magnitude
	localparam logic [MAG_W-1:0] SINE_POS_MAX = MAG_W'(32767);
	localparam logic [MAG_W-1:0] SINE_NEG_MAX = MAG_W'(32768);

	// Rounding offsets
	localparam logic [PROD_W-1:0] P_HALF   = PROD_W'(64'd1 << (P_SH - 1));
	localparam logic [ACC_W-1:0]  R_HALF   = ACC_W'(64'd1 << (R_SH - 1));
	localparam logic [S_W-1:0]    MAG_HALF = S_W'(64'd1 << (Q_SH - 1));

	// Rounded 2^32 / ((2i+2)(2i+3)) for i = 0 .. 8
	localparam logic [R_W-1:0] RECIP [0:TERM_MAX-2] = '{
		30'd715827883,
		30'd214748365,
		30'd102261126,
		30'd59652324,
		30'd39045157,
		30'd27531842,
		30'd20452225,
		30'd15790321,
		30'd12558384
	};

	// Control that travels with every item
	typedef struct packed {
		logic valid;
		logic xneg;
		logic oor;
	} ctl_t;

	// Arithmetic state between term stages
	typedef struct packed {
		logic [X2_W-1:0]       x2;
		logic [T_W-1:0]        term;
		logic signed [S_W-1:0] sum;
	} dat_t;

endpackage
`default_nettype wire

// ----- src/taysin_term.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// taysin_term
// One series term in three stages: multiply by x^2, multiply by the
// reciprocal of (2i+2)(2i+3) in two halves, then merge and accumulate.
// ----------------------------------------------------------------------------
module taysin_term #(
	parameter int TERM_IDX = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire taysin_pkg::ctl_t  ctl_in,
	input  wire taysin_pkg::dat_t  dat_in,
	output taysin_pkg::ctl_t       ctl_out,
	output taysin_pkg::dat_t       dat_out
);

	localparam logic [taysin_pkg::R_W-1:0] RCP = taysin_pkg::RECIP[TERM_IDX-1];
	localparam bit SUB = (TERM_IDX % 2) == 1;

	taysin_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3;

	logic [taysin_pkg::PROD_W-1:0]  prod_s1;
	logic [taysin_pkg::X2_W-1:0]    x2_s1, x2_s2;
	logic signed [taysin_pkg::S_W-1:0] sum_s1, sum_s2;
	logic [taysin_pkg::PPH_W-1:0]   pph_s2;
	logic [taysin_pkg::PPL_W-1:0]   ppl_s2;
	taysin_pkg::dat_t               dat_s3;

	logic [taysin_pkg::PROD_W-1:0]  prod_rnd;
	logic [taysin_pkg::P_W-1:0]     p_val;
	logic [taysin_pkg::ACC_W-1:0]   acc;
	logic [taysin_pkg::T_W-1:0]     term_next;
	logic signed [taysin_pkg::S_W-1:0] term_ext;

	// Round the x^2 product back to Q24
	always_comb begin
		prod_rnd = prod_s1 + taysin_pkg::P_HALF;
		p_val    = prod_rnd[taysin_pkg::PROD_W-1:taysin_pkg::P_SH];
	end

	// Merge the halves, round to Q24 and widen for the sum
	always_comb begin
		acc = {1'b0, pph_s2, {taysin_pkg::PL_W{1'b0}}}
			+ {{(taysin_pkg::ACC_W-taysin_pkg::PPL_W){1'b0}}, ppl_s2}
			+ taysin_pkg::R_HALF;
		term_next = acc[taysin_pkg::R_SH+taysin_pkg::T_W-1:taysin_pkg::R_SH];
		term_ext  = {{(taysin_pkg::S_W-taysin_pkg::T_W){1'b0}}, term_next};
	end

	// Advance control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Advance arithmetic
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= dat_in.term * dat_in.x2;
			x2_s1   <= dat_in.x2;
			sum_s1  <= dat_in.sum;

			pph_s2  <= p_val[taysin_pkg::P_W-1:taysin_pkg::PL_W] * RCP;
			ppl_s2  <= p_val[taysin_pkg::PL_W-1:0] * RCP;
			x2_s2   <= x2_s1;
			sum_s2  <= sum_s1;

			dat_s3.x2   <= x2_s2;
			dat_s3.term <= term_next;
			dat_s3.sum  <= SUB ? (sum_s2 - term_ext) : (sum_s2 + term_ext);
		end
	end

	assign ctl_out = ctl_s3;
	assign dat_out = dat_s3;

endmodule
`default_nettype wire

// ----- src/taylor_sine_top.sv -----
// Throughput: one item per cycle while the output buffer has room; every stage advances together, and the
// two-entry output buffer lets the pipeline keep taking items while one
// result waits. s_tready falls only when that buffer is full.
// Reset: arst_n clears all valid bits and the output buffer count at once.
`default_nettype none
// ----------------------------------------------------------------------------
// taylor_sine_top
// Sine of a Q3.12 angle as a truncated Maclaurin series, result Q1.14
// saturated; angles beyond 6.4 rad flag out of range and give zero.
// ----------------------------------------------------------------------------
module taylor_sine_top #(
	parameter int TERM_COUNT = taysin_pkg::TERM_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] angle
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] sine
	output logic             m_tuser    // [0] out_of_range
);

	logic en;

	// Input stage
	taysin_pkg::ctl_t             ctl_s1;
	logic [taysin_pkg::X_W-1:0]   x_s1;
	logic [taysin_pkg::ANGLE_W-1:0] angle_mag;
	logic                         angle_oor;

	// Seed stage
	taysin_pkg::ctl_t ctl_s2;
	taysin_pkg::dat_t dat_s2;

	// Term chain
	taysin_pkg::ctl_t ctl_chain [TERM_COUNT];
	taysin_pkg::dat_t dat_chain [TERM_COUNT];

	// Final rounding stage
	taysin_pkg::ctl_t               ctl_s3;
	logic                           sneg_s3;
	logic [taysin_pkg::MAG_W-1:0]   mag_s3;
	taysin_pkg::ctl_t               ctl_end;
	taysin_pkg::dat_t               dat_end;
	logic                           sum_neg;
	logic [taysin_pkg::S_W-1:0]     sum_mag;
	logic [taysin_pkg::S_W:0]       sum_rnd;

	// Saturation and output buffer
	logic                           res_neg;
	logic [taysin_pkg::SINE_W-1:0]  res_sine;
	logic [taysin_pkg::SINE_W-1:0]  buf0_sine_q, buf1_sine_q;
	logic                           buf0_oor_q, buf1_oor_q;
	logic [1:0]                     cnt_q;
	logic                           push, pop;

	// Move the whole pipeline while the output buffer has room
	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;

	// Take the angle apart into sign and magnitude
	always_comb begin
		angle_mag = s_tdata[15] ? (~s_tdata + 16'd1) : s_tdata;
		angle_oor = angle_mag > taysin_pkg::ANGLE_LIMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1.valid <= s_tvalid;
			ctl_s1.xneg  <= s_tdata[15];
			ctl_s1.oor   <= angle_oor;
			ctl_s2       <= ctl_s1;
		end
	end

	// Zero the magnitude of rejected angles, then seed x^2, first term and sum
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1        <= angle_oor ? '0 : angle_mag[taysin_pkg::X_W-1:0];
			dat_s2.x2   <= x_s1 * x_s1;
			dat_s2.term <= {{(taysin_pkg::T_W-taysin_pkg::X_W-taysin_pkg::FRAC_W){1'b0}},
				x_s1, {taysin_pkg::FRAC_W{1'b0}}};
			dat_s2.sum  <= {{(taysin_pkg::S_W-taysin_pkg::X_W-taysin_pkg::FRAC_W){1'b0}},
				x_s1, {taysin_pkg::FRAC_W{1'b0}}};
		end
	end

	assign ctl_chain[0] = ctl_s2;
	assign dat_chain[0] = dat_s2;

	// One three-stage unit per further term
	for (genvar g = 1; g < TERM_COUNT; g++) begin : g_term
		taysin_term #(
			.TERM_IDX (g)
		) u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_chain[g-1]),
			.dat_in  (dat_chain[g-1]),
			.ctl_out (ctl_chain[g]),
			.dat_out (dat_chain[g])
		);
	end

	assign ctl_end = ctl_chain[TERM_COUNT-1];
	assign dat_end = dat_chain[TERM_COUNT-1];

	// Round the sum magnitude to Q14, half away from zero
	always_comb begin
		sum_neg = dat_end.sum[taysin_pkg::S_W-1];
		sum_mag = sum_neg ? (~dat_end.sum + {{(taysin_pkg::S_W-1){1'b0}}, 1'b1})
			: dat_end.sum;
		sum_rnd = {1'b0, sum_mag} + {1'b0, taysin_pkg::MAG_HALF};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_end;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sneg_s3 <= sum_neg;
			mag_s3  <= sum_rnd[taysin_pkg::S_W:taysin_pkg::Q_SH];
		end
	end

	// Apply sign, saturate, force zero when out of range
	always_comb begin
		res_neg = (ctl_s3.xneg != sneg_s3) && (mag_s3 != '0);
		if (ctl_s3.oor) begin
			res_sine = '0;
		end else if (res_neg) begin
			if (mag_s3 > taysin_pkg::SINE_NEG_MAX) begin
				res_sine = 16'h8000;
			end else begin
				res_sine = ~mag_s3[taysin_pkg::SINE_W-1:0] + 16'd1;
			end
		end else if (mag_s3 > taysin_pkg::SINE_POS_MAX) begin
			res_sine = 16'h7fff;
		end else begin
			res_sine = mag_s3[taysin_pkg::SINE_W-1:0];
		end
	end

	assign push = en && ctl_s3.valid;
	assign pop  = m_tvalid && m_tready;

	// Hold up to two results; entry 0 is the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && (pop || cnt_q == 2'd0)) begin
			buf0_sine_q <= res_sine;
			buf0_oor_q  <= ctl_s3.oor;
		end else if (pop) begin
			buf0_sine_q <= buf1_sine_q;
			buf0_oor_q  <= buf1_oor_q;
		end
		if (push && !pop && cnt_q == 2'd1) begin
			buf1_sine_q <= res_sine;
			buf1_oor_q  <= ctl_s3.oor;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = buf0_sine_q;
	assign m_tuser  = buf0_oor_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of bounds");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 16'd0))
		else $error("out of range result with nonzero sine");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("output buffer count did not drop on pop");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !m_tready) |=> (cnt_q == 2'd2 && $stable(m_tdata)))
		else $error("full output buffer changed while stalled");
`endif

endmodule
`default_nettype wire
